/* hdl/dcd_pkg.sv */
// shared constants for the dark channel dehaze unit
// no dependencies
package dcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 15;
  localparam int RING_ROWS  = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(RING_ROWS);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int DEPTH      = RING_ROWS * MAX_WIDTH;
  localparam int IDX_W      = 23;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_ALIGHT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [3:0]  RST_WINDOW = 4'd15;
  localparam logic [7:0]  RST_ALIGHT = 8'd250;
  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [11:0] RST_HEIGHT = 12'd768;
  localparam logic [3:0]  RST_LO     = 4'd7;
  localparam logic [3:0]  RST_HI     = 4'd7;
  localparam logic [IDX_W-1:0] RST_TOTAL = 23'd786432;
  localparam logic [IDX_W-1:0] RST_DELAY = 23'd7175;

endpackage

/* hdl/dcd_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/dcd_div.sv */
// iterative restoring divider, 16-bit dividend by 8-bit divisor, one bit a cycle
// no dependencies
module dcd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [8:0]  rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [7:0]  dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [8:0]  shifted;

  always_comb begin
    shifted = {rem_q[7:0], quo_q[15]};
    quo_d   = {quo_q[14:0], 1'b0};
    rem_d   = shifted;
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d    = shifted - {1'b0, dvs_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;

endmodule

/* hdl/dark_channel_dehaze_unit.sv */
// dark channel dehaze unit: line stores in two rams, window scan, recovery by division
// depends on dcd_pkg, dcd_ram, dcd_div
// an item without a result passes the check state, after the geometry state at a frame's
// first pixel; one with a result goes on through the window scan, which reads the dark ram
// one entry a cycle, and the divider's 16 steps; one item in work at a time, one result
// waits at the output while the next is worked; reset clears counters, rams are not
module dark_channel_dehaze_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue_in, green_in, red_in
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // blue_out, green_out, red_out, window_dark
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int CW = dcd_pkg::COL_W;
  localparam int IW = dcd_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_GEO, S_CHK, S_SCAN, S_LAST, S_LOAD, S_DIV, S_PUT
  } state_e;

  state_e state_q;

  logic [3:0]  win_q;
  logic [7:0]  alight_q;
  logic [10:0] width_q;
  logic [11:0] height_q;

  logic [10:0] gw_q;
  logic [11:0] gh_q;
  logic [3:0]  lo_q, hi_q;
  logic [IW-1:0] total_q, delay_q;

  logic [CW-1:0] in_col_q, out_col_q;
  logic [11:0]   in_row_q, out_row_q;
  logic [IW-1:0] in_idx_q, out_idx_q;

  logic [11:0]   r_q, r1_q;
  logic [CW-1:0] c_q, c0_q, c1_q;
  logic [7:0]    dmin_q;
  logic          cmp_q;
  logic [23:0]   pix_q;
  logic [2:0]    neg_q;

  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_last_q;

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= dcd_pkg::RST_WINDOW;
      alight_q <= dcd_pkg::RST_ALIGHT;
      width_q  <= dcd_pkg::RST_WIDTH;
      height_q <= dcd_pkg::RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcd_pkg::REG_WINDOW: win_q    <= cfg_data_i[3:0];
        dcd_pkg::REG_ALIGHT: alight_q <= cfg_data_i[7:0];
        dcd_pkg::REG_WIDTH:  width_q  <= cfg_data_i[10:0];
        dcd_pkg::REG_HEIGHT: height_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // input side
  logic       acc;
  logic       is_pix;
  logic       latch;
  logic [3:0] s_sat, lo_new, hi_new;
  logic [10:0] w_new, gw_eff;
  logic [11:0] h_new;
  logic [7:0]  b_in, g_in, r_in, dk;
  logic [10:0] in_col_inc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign is_pix = !s_axis_tuser && (in_row_q < gh_q);
  assign latch  = is_pix && (in_row_q == 12'd0) && (in_col_q == '0);
  assign b_in   = s_axis_tdata[7:0];
  assign g_in   = s_axis_tdata[15:8];
  assign r_in   = s_axis_tdata[23:16];

  always_comb begin
    s_sat = win_q;
    if (win_q < 4'd3) s_sat = 4'd3;
    if (win_q > 4'(dcd_pkg::MAX_WINDOW)) s_sat = 4'(dcd_pkg::MAX_WINDOW);
    lo_new = s_sat >> 1;
    hi_new = s_sat - 4'd1 - lo_new;
    w_new = width_q;
    if (width_q == 11'd0) w_new = 11'd1;
    if (width_q > 11'(dcd_pkg::MAX_WIDTH)) w_new = 11'(dcd_pkg::MAX_WIDTH);
    h_new = (height_q == 12'd0) ? 12'd1 : height_q;
    gw_eff = latch ? w_new : gw_q;
    dk = (b_in < g_in) ? b_in : g_in;
    if (dk > r_in) dk = r_in;
    in_col_inc = {1'b0, in_col_q} + 11'd1;
  end

  // window bounds for the current output
  logic [11:0]   r0_n, r1_n, hm1;
  logic [12:0]   r_hi;
  logic [CW-1:0] c0_n, c1_n;
  logic [10:0]   c_hi, wm1;
  logic          due;

  always_comb begin
    r0_n = (out_row_q >= {8'd0, lo_q}) ? out_row_q - {8'd0, lo_q} : 12'd0;
    r_hi = {1'b0, out_row_q} + {9'd0, hi_q};
    hm1  = gh_q - 12'd1;
    r1_n = (r_hi > {1'b0, hm1}) ? hm1 : r_hi[11:0];
    c0_n = (out_col_q >= CW'(lo_q)) ? out_col_q - CW'(lo_q) : '0;
    c_hi = {1'b0, out_col_q} + {7'd0, hi_q};
    wm1  = gw_q - 11'd1;
    c1_n = (c_hi > wm1) ? wm1[CW-1:0] : c_hi[CW-1:0];
    due  = (out_idx_q < total_q) &&
           ((in_row_q >= gh_q) || ((out_idx_q + delay_q) < in_idx_q));
  end

  // line stores
  logic [7:0]  dark_rd;
  logic [23:0] color_rd;
  logic [dcd_pkg::ADDR_W-1:0] waddr;

  assign waddr = {in_row_q[dcd_pkg::SLOT_W-1:0], in_col_q};

  dcd_ram #(.WIDTH(8), .DEPTH(dcd_pkg::DEPTH)) u_dark_ram (
    .clk_i   (clk_i),
    .we_i    (acc && is_pix),
    .waddr_i (waddr),
    .wdata_i (dk),
    .raddr_i ({r_q[dcd_pkg::SLOT_W-1:0], c_q}),
    .rdata_o (dark_rd)
  );

  dcd_ram #(.WIDTH(24), .DEPTH(dcd_pkg::DEPTH)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (acc && is_pix),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i ({out_row_q[dcd_pkg::SLOT_W-1:0], out_col_q}),
    .rdata_o (color_rd)
  );

  // recovery dividers
  logic [7:0]  ch [3];
  logic [15:0] mag [3];
  logic [15:0] quot [3];
  logic [2:0]  done;
  logic        div_start;
  logic [7:0]  divisor;

  assign div_start = (state_q == S_LOAD);
  assign divisor   = alight_q - dmin_q;

  for (genvar i = 0; i < 3; i++) begin : g_div
    assign ch[i] = color_rd[8*i +: 8];
    always_comb begin
      if (ch[i] < alight_q) mag[i] = 16'(alight_q - ch[i]) * 16'(alight_q);
      else mag[i] = 16'(ch[i] - alight_q) * 16'(alight_q);
    end
    dcd_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (mag[i]),
      .divisor_i  (divisor),
      .done_o     (done[i]),
      .quot_o     (quot[i])
    );
  end

  logic [7:0] rec [3];
  logic [17:0] v [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = neg_q[i] ? {10'd0, alight_q} - {2'd0, quot[i]}
                      : {10'd0, alight_q} + {2'd0, quot[i]};
      if (dmin_q >= alight_q) begin
        if (pix_q[8*i +: 8] > alight_q) rec[i] = 8'd255;
        else if (pix_q[8*i +: 8] < alight_q) rec[i] = 8'd0;
        else rec[i] = alight_q;
      end else if (v[i][17]) begin
        rec[i] = 8'd0;
      end else if (v[i] > 18'd255) begin
        rec[i] = 8'd255;
      end else begin
        rec[i] = v[i][7:0];
      end
    end
  end

  logic last_out;
  logic put;
  assign last_out = (out_idx_q == total_q - IW'(1));
  // result moves into the output register once that is free or being taken
  assign put = ((state_q == S_DIV && done[0]) || state_q == S_PUT) &&
               (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      gw_q      <= dcd_pkg::RST_WIDTH;
      gh_q      <= dcd_pkg::RST_HEIGHT;
      lo_q      <= dcd_pkg::RST_LO;
      hi_q      <= dcd_pkg::RST_HI;
      total_q   <= dcd_pkg::RST_TOTAL;
      delay_q   <= dcd_pkg::RST_DELAY;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_idx_q  <= '0;
      out_idx_q <= '0;
      cmp_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      cmp_q <= (state_q == S_SCAN);
      if (put) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (latch) begin
              gw_q <= w_new;
              gh_q <= h_new;
              lo_q <= lo_new;
              hi_q <= hi_new;
            end
            if (is_pix) begin
              in_idx_q <= in_idx_q + IW'(1);
              if (in_col_inc >= gw_eff) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + 12'd1;
              end else begin
                in_col_q <= in_col_inc[CW-1:0];
              end
            end
            state_q <= latch ? S_GEO : S_CHK;
          end
        end
        S_GEO: begin
          total_q <= IW'(gw_q * gh_q);
          delay_q <= IW'(hi_q * gw_q) + IW'(hi_q);
          state_q <= S_CHK;
        end
        S_CHK: begin
          state_q <= due ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (c_q == c1_q && r_q == r1_q) state_q <= S_LAST;
        end
        S_LAST: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (done[0]) state_q <= put ? S_IDLE : S_PUT;
        end
        S_PUT: begin
          if (put) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (put) begin
        if (last_out) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          in_idx_q  <= '0;
          out_idx_q <= '0;
        end else begin
          out_idx_q <= out_idx_q + IW'(1);
          if ({1'b0, out_col_q} + 11'd1 >= gw_q) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 12'd1;
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  // window walk and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHK) begin
      r1_q   <= r1_n;
      c0_q   <= c0_n;
      c1_q   <= c1_n;
      r_q    <= r0_n;
      c_q    <= c0_n;
      dmin_q <= 8'd255;
    end else begin
      if (state_q == S_SCAN) begin
        if (c_q == c1_q) begin
          c_q <= c0_q;
          if (r_q != r1_q) r_q <= r_q + 12'd1;
        end else begin
          c_q <= c_q + CW'(1);
        end
      end
      if (cmp_q && dark_rd < dmin_q) dmin_q <= dark_rd;
    end
    if (state_q == S_LOAD) begin
      pix_q <= color_rd;
      for (int i = 0; i < 3; i++) neg_q[i] <= ch[i] < alight_q;
    end
    if (put) begin
      m_data_q <= {dmin_q, rec[2], rec[1], rec[0]};
      m_last_q <= last_out;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

/* tb/dark_channel_dehaze_unit_chk.sv */
// checker for the dark channel dehaze unit: watches the config, input and output streams,
// predicts each recovered pixel and compares it field by field
// depends on dcd_pkg
module dark_channel_dehaze_unit_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] dark;
    logic       last;
  } dehazed_px_t;

  dehazed_px_t px_queue[$];

  logic [7:0]  dark_rows [dcd_pkg::RING_ROWS][dcd_pkg::MAX_WIDTH];
  logic [23:0] color_rows[dcd_pkg::RING_ROWS][dcd_pkg::MAX_WIDTH];
  int unsigned wr_col, wr_row, rd_col, rd_row;
  int unsigned lat_w, lat_h, lat_lo, lat_hi;
  logic [3:0]  reg_win;
  logic [7:0]  reg_al;
  logic [10:0] reg_w;
  logic [11:0] reg_h;

  assign pending_o = px_queue.size();

  task automatic latch_geo();
    int unsigned s;
    s = reg_win;
    if (s < 3) s = 3;
    if (s > dcd_pkg::MAX_WINDOW) s = dcd_pkg::MAX_WINDOW;
    lat_lo = s / 2;
    lat_hi = s - 1 - lat_lo;
    lat_w = reg_w;
    if (lat_w < 1) lat_w = 1;
    if (lat_w > dcd_pkg::MAX_WIDTH) lat_w = dcd_pkg::MAX_WIDTH;
    lat_h = reg_h;
    if (lat_h < 1) lat_h = 1;
  endtask

  function automatic logic [7:0] recover_chan(int c, int a, int d);
    int v;
    if (d >= a) return (c > a) ? 8'd255 : ((c < a) ? 8'd0 : a[7:0]);
    v = a + ((c - a) * a) / (a - d);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic predict_px(logic act, logic [23:0] data);
    int unsigned n, total, q, dly, r0, r1, c0, c1, dmin, slot, dk;
    logic [23:0] pix;
    dehazed_px_t px;
    bit done;
    done = wr_row >= lat_h;
    if (!act && !done) begin
      dk = data[7:0];
      if (data[15:8] < dk) dk = data[15:8];
      if (data[23:16] < dk) dk = data[23:16];
      if (wr_row == 0 && wr_col == 0) latch_geo();
      slot = wr_row % dcd_pkg::RING_ROWS;
      dark_rows[slot][wr_col] = dk[7:0];
      color_rows[slot][wr_col] = data;
      wr_col++;
      if (wr_col >= lat_w) begin
        wr_col = 0;
        wr_row++;
      end
      done = wr_row >= lat_h;
    end
    n = wr_row * lat_w + wr_col;
    total = lat_w * lat_h;
    q = rd_row * lat_w + rd_col;
    dly = lat_hi * lat_w + lat_hi;
    if (q >= total) return;
    if (!done && q + dly >= n) return;
    r0 = (rd_row >= lat_lo) ? rd_row - lat_lo : 0;
    r1 = rd_row + lat_hi;
    if (r1 > lat_h - 1) r1 = lat_h - 1;
    c0 = (rd_col >= lat_lo) ? rd_col - lat_lo : 0;
    c1 = rd_col + lat_hi;
    if (c1 > lat_w - 1) c1 = lat_w - 1;
    dmin = 255;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        if (dark_rows[r % dcd_pkg::RING_ROWS][c] < dmin)
          dmin = dark_rows[r % dcd_pkg::RING_ROWS][c];
    pix = color_rows[rd_row % dcd_pkg::RING_ROWS][rd_col];
    px.blue  = recover_chan(pix[7:0], reg_al, dmin);
    px.green = recover_chan(pix[15:8], reg_al, dmin);
    px.red   = recover_chan(pix[23:16], reg_al, dmin);
    px.dark  = dmin[7:0];
    px.last  = (q == total - 1);
    px_queue.push_back(px);
    if (q == total - 1) begin
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    end else begin
      rd_col++;
      if (rd_col >= lat_w) begin
        rd_col = 0;
        rd_row++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dehazed_px_t exp_px, got_px;
    if (!rst_ni) begin
      px_queue.delete();
      fail_count_o = 0;
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
      reg_win = dcd_pkg::RST_WINDOW;
      reg_al  = dcd_pkg::RST_ALIGHT;
      reg_w   = dcd_pkg::RST_WIDTH;
      reg_h   = dcd_pkg::RST_HEIGHT;
      latch_geo();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                  m_axis_tdata[31:24], m_axis_tlast};
        if (px_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got_px);
        end else begin
          exp_px = px_queue.pop_front();
          if (got_px !== exp_px) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp b=%0d g=%0d r=%0d d=%0d l=%0d",
                        " got b=%0d g=%0d r=%0d d=%0d l=%0d"},
                       exp_px.blue, exp_px.green, exp_px.red, exp_px.dark, exp_px.last,
                       got_px.blue, got_px.green, got_px.red, got_px.dark, got_px.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          dcd_pkg::REG_WINDOW: reg_win = cfg_data_i[3:0];
          dcd_pkg::REG_ALIGHT: reg_al  = cfg_data_i[7:0];
          dcd_pkg::REG_WIDTH:  reg_w   = cfg_data_i[10:0];
          dcd_pkg::REG_HEIGHT: reg_h   = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_px(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

/* tb/dark_channel_dehaze_unit_tb.sv */
// testbench top for the dark channel dehaze unit: drives frames, drain requests and
// register writes under varied idling, checker module judges results
// depends on dcd_pkg, dark_channel_dehaze_unit, dark_channel_dehaze_unit_chk
module dark_channel_dehaze_unit_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  int          fail_count, pending;
  idle_mode_e  idle_mode = IDLE_NONE;
  logic        hold_req = 1'b0;
  bit          hold_done = 0;
  int          hold_left = 0;
  int          sent_items = 0;
  int          quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  dark_channel_dehaze_unit u_top (.*);

  dark_channel_dehaze_unit_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver side stalls, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      m_axis_tready <= ($urandom_range(99) >= 68);
    end else if (idle_mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 19);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(logic act, logic [23:0] data);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 68 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = data;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic set_geo(int win, int al, int w, int h);
    wait_drained();
    write_reg(dcd_pkg::REG_WINDOW, 12'(win));
    write_reg(dcd_pkg::REG_ALIGHT, 12'(al));
    write_reg(dcd_pkg::REG_WIDTH, 12'(w));
    write_reg(dcd_pkg::REG_HEIGHT, 12'(h));
  endtask

  // one frame of pixels followed by enough drain requests to flush it
  task automatic run_frame(int win, int w, int h, bit noisy, bit do_pause, bit do_hold);
    int s, lo, hi, total, dly, emitted, pend;
    s = (win < 3) ? 3 : (win > dcd_pkg::MAX_WINDOW) ? dcd_pkg::MAX_WINDOW : win;
    lo = s / 2;
    hi = s - 1 - lo;
    w = (w < 1) ? 1 : (w > dcd_pkg::MAX_WIDTH) ? dcd_pkg::MAX_WIDTH : w;
    h = (h < 1) ? 1 : h;
    total = w * h;
    dly = hi * w + hi;
    emitted = ((total - 1 > dly) ? total - 1 - dly : 0) + 1;
    pend = total - emitted;
    for (int k = 0; k < total; k++) begin
      if (noisy && k > 0 && $urandom_range(19) == 0) send_item(1'b1, 24'($urandom));
      if (do_hold && k == total / 2) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      if (do_pause && k == total / 2) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      send_item(1'b0, {pick_chan(), pick_chan(), pick_chan()});
    end
    for (int k = 0; k < pend; k++) send_item(1'($urandom_range(1)), 24'($urandom));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  initial begin
    int win, al, w, h, frame_no;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_geo(3, 255, 4, 3);
    run_frame(3, 4, 3, 0, 1, 0);
    set_geo(0, 1, 5, 2);
    run_frame(0, 5, 2, 1, 0, 0);
    set_geo(15, 250, 3, 4);
    run_frame(15, 3, 4, 0, 0, 0);
    set_geo(2, 0, 2, 2);
    run_frame(2, 2, 2, 0, 0, 0);
    set_geo(7, 128, 0, 0);
    run_frame(7, 0, 0, 0, 0, 0);
    set_geo(15, 200, 30, 1);
    run_frame(15, 30, 1, 0, 0, 0);
    set_geo(14, 77, 16, 4095);
    write_reg(dcd_pkg::REG_HEIGHT, 12'd1);
    run_frame(14, 16, 1, 0, 0, 0);
    set_geo(3, 255, 1, 4095);
    write_reg(dcd_pkg::REG_HEIGHT, 12'd40);
    run_frame(3, 1, 40, 0, 0, 1);

    frame_no = 0;
    while (sent_items < 880) begin
      idle_mode = idle_mode_e'(frame_no % 4);
      win = $urandom_range(15);
      case ($urandom_range(4))
        0: al = 1;
        1: al = 255;
        default: al = $urandom_range(255);
      endcase
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(40, 20);
        h = $urandom_range(3, 1);
      end else begin
        w = $urandom_range(12, 1);
        h = $urandom_range(8, 1);
      end
      set_geo(win, al, w, h);
      run_frame(win, w, h, 1, frame_no == 3, 0);
      frame_no++;
    end
    hold_req = 1'b0;
    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dcd_pkg.sv
hdl/dcd_ram.sv
hdl/dcd_div.sv
hdl/dark_channel_dehaze_unit.sv
tb/dark_channel_dehaze_unit_chk.sv
tb/dark_channel_dehaze_unit_tb.sv
